/* rtl/drop_to_complementarity_assert.svh */
// Assertion macros shared by the complementarity drop RTL.
`ifndef DROP_TO_COMPLEMENTARITY_ASSERT_SVH
`define DROP_TO_COMPLEMENTARITY_ASSERT_SVH

// Check expr in the cycle after trig, sampled on clk, off during reset.
`define DTC_ASSERT_NEXT(label, trig, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (expr)) \
        else $error("dtc: next-cycle check failed");

// Check expr in the same cycle as trig.
`define DTC_ASSERT_NOW(label, trig, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (expr)) \
        else $error("dtc: same-cycle check failed");

`endif

/* rtl/dtc_pkg.sv */
// Shared types, constants and IEEE double helpers for the complementarity drop.
package dtc_pkg;

    typedef logic [63:0] dbl_t;

    localparam dbl_t POS_ZERO    = 64'h0000_0000_0000_0000;
    localparam dbl_t DEFAULT_NAN = 64'hFFF8_0000_0000_0000;
    localparam dbl_t QUIET_BIT   = 64'h0008_0000_0000_0000;
    localparam logic [10:0] EXP_MAX = 11'h7FF;

    function automatic logic is_nan(input dbl_t a);
        return (a[62:52] == EXP_MAX) && (a[51:0] != 52'd0);
    endfunction

    function automatic logic is_inf(input dbl_t a);
        return (a[62:52] == EXP_MAX) && (a[51:0] == 52'd0);
    endfunction

    // Total-order key for non-NaN doubles (zeros handled by the caller)
    function automatic dbl_t ord_key(input dbl_t a);
        return a[63] ? ~a : {1'b1, a[62:0]};
    endfunction

    // a < b with C semantics
    function automatic logic fp_lt(input dbl_t a, input dbl_t b);
        logic both_zero;
        both_zero = (a[62:0] == 63'd0) && (b[62:0] == 63'd0);
        return !is_nan(a) && !is_nan(b) && !both_zero && (ord_key(a) < ord_key(b));
    endfunction

    function automatic logic fp_eq(input dbl_t a, input dbl_t b);
        logic both_zero;
        both_zero = (a[62:0] == 63'd0) && (b[62:0] == 63'd0);
        return !is_nan(a) && !is_nan(b) && ((a == b) || both_zero);
    endfunction

    function automatic logic fp_ge(input dbl_t a, input dbl_t b);
        return !is_nan(a) && !is_nan(b) && !fp_lt(a, b);
    endfunction

    // Significand with hidden bit
    function automatic logic [52:0] mant(input dbl_t a);
        return {(a[62:52] != 11'd0), a[51:0]};
    endfunction

    // Effective exponent (subnormals use 1)
    function automatic logic [10:0] exp_eff(input dbl_t a);
        return (a[62:52] == 11'd0) ? 11'd1 : a[62:52];
    endfunction

    // Leading zero count of a 106-bit word (106 when zero)
    function automatic logic [6:0] lzc106(input logic [105:0] v);
        logic [6:0] n;
        n = 7'd106;
        for (int i = 0; i < 106; i++)
        begin
            if (v[i])
                n = 7'(105 - i);
        end
        return n;
    endfunction

    // Leading zero count of a 56-bit word (56 when zero)
    function automatic logic [5:0] lzc56(input logic [55:0] v);
        logic [5:0] n;
        n = 6'd56;
        for (int i = 0; i < 56; i++)
        begin
            if (v[i])
                n = 6'(55 - i);
        end
        return n;
    endfunction

endpackage

/* rtl/dtc_channels.sv */
// Request and result channel interfaces of the complementarity drop.
interface dtc_item_if;
    logic          valid;
    logic          ready;
    dtc_pkg::dbl_t primal_value;
    dtc_pkg::dbl_t lower_slack;
    dtc_pkg::dbl_t upper_slack;
    dtc_pkg::dbl_t lower_dual;
    dtc_pkg::dbl_t upper_dual;
    dtc_pkg::dbl_t lower_bound;
    dtc_pkg::dbl_t upper_bound;
    logic          has_lower;
    logic          has_upper;

    modport source (output valid, primal_value, lower_slack, upper_slack, lower_dual,
                    upper_dual, lower_bound, upper_bound, has_lower, has_upper,
                    input ready);
    modport sink (input valid, primal_value, lower_slack, upper_slack, lower_dual,
                  upper_dual, lower_bound, upper_bound, has_lower, has_upper,
                  output ready);
endinterface

interface dtc_result_if;
    logic          valid;
    logic          ready;
    dtc_pkg::dbl_t dropped_primal;
    dtc_pkg::dbl_t dropped_dual;

    modport source (output valid, dropped_primal, dropped_dual, input ready);
    modport sink (input valid, dropped_primal, dropped_dual, output ready);
endinterface

/* rtl/drop_to_complementarity.sv */
// Complementarity drop: one request per variable in, one result per variable out.
//
// Channels: "items" carries one variable per request (x, slacks, duals, bounds,
// bound flags, all doubles except the flags); "results" returns the dropped
// primal value and reduced cost. Both use valid/ready, a request moves when
// both are high.
// Throughput: one request per cycle while the output is not stalled. The seven register stages are set by the
// two double multipliers of the ratio test (partial products, sum, leading
// zero count, normalize, subnormal shift, round) with the double subtract
// for zl - zu running alongside; the final select sits in the output stage.
// Reset: all stage valid bits clear, the pipeline comes up empty and ready.
// Stall: while results.valid is high and results.ready low, the whole
// pipeline holds and items.ready is low; nothing is dropped or repeated.
`include "drop_to_complementarity_assert.svh"

module drop_to_complementarity (
    input  logic                clk,
    input  logic                rst_n,
    dtc_item_if.sink            items,
    dtc_result_if.source        results
);

    typedef struct packed {
        dtc_pkg::dbl_t lb;
        dtc_pkg::dbl_t ub;
        dtc_pkg::dbl_t xv;   // max(x, lb) in stage 1, clamped x after
        logic          eq;
        logic          gel;
        logic          geu;
        logic          hl;
        logic          hu;
    } ctl_t;

    typedef struct packed {
        logic nan;
        logic inf;
        logic zero;
        logic sign;
    } mflag_t;

    typedef enum logic [1:0] {SIDE_NONE, SIDE_LOWER, SIDE_UPPER} side_t;

    logic en;
    logic [5:0] vld_reg;
    logic out_valid_reg;
    dtc_pkg::dbl_t out_primal_reg;
    dtc_pkg::dbl_t out_dual_reg;

    ctl_t s1_ctl_reg, s2_ctl_reg, s3_ctl_reg, s4_ctl_reg, s5_ctl_reg, s6_ctl_reg;
    ctl_t s1_ctl_next, s2_ctl_next;

    // multiplier lanes: 0 = zl*xu, 1 = zu*xl
    dtc_pkg::dbl_t mul_a [2];
    dtc_pkg::dbl_t mul_b [2];
    logic [51:0]  s1_pphh_reg [2];
    logic [52:0]  s1_pphl_reg [2];
    logic [52:0]  s1_pplh_reg [2];
    logic [53:0]  s1_ppll_reg [2];
    logic [11:0]  s1_esum_reg [2];
    mflag_t       s1_mf_reg [2];
    logic [105:0] s2_p_reg [2];
    logic [11:0]  s2_esum_reg [2];
    mflag_t       s2_mf_reg [2];
    logic [105:0] s3_p_reg [2];
    logic [6:0]   s3_lz_reg [2];
    logic [11:0]  s3_esum_reg [2];
    mflag_t       s3_mf_reg [2];
    logic [105:0] s4_n_reg [2];
    logic signed [12:0] s4_e_reg [2];
    mflag_t       s4_mf_reg [2];
    logic [10:0]  s5_ef_reg [2];
    logic [51:0]  s5_frac_reg [2];
    logic         s5_g_reg [2];
    logic         s5_st_reg [2];
    logic         s5_ovf_reg [2];
    mflag_t       s5_mf_reg [2];
    dtc_pkg::dbl_t s6_prod_reg [2];

    // subtract path zl - zu
    logic [52:0]  s1_big_reg, s1_small_reg;
    logic [10:0]  s1_ebig_reg, s1_d_reg;
    logic         s1_esub_reg, s1_rsign_reg, s1_spec_reg;
    dtc_pkg::dbl_t s1_specval_reg;
    logic [56:0]  s2_sum_reg;
    logic [10:0]  s2_ebig_reg;
    logic         s2_rsign_reg, s2_spec_reg;
    dtc_pkg::dbl_t s2_specval_reg;
    logic [55:0]  s3_n_reg;
    logic [10:0]  s3_e_reg;
    logic [5:0]   s3_lz_reg_sub;
    logic         s3_zero_reg, s3_rsign_reg, s3_spec_reg;
    dtc_pkg::dbl_t s3_specval_reg;
    logic [55:0]  s4_m_reg;
    logic [10:0]  s4_ef_reg;
    logic         s4_ovf_reg, s4_zero_reg, s4_rsign_reg, s4_spec_reg;
    dtc_pkg::dbl_t s4_specval_reg;
    dtc_pkg::dbl_t s5_diff_reg, s6_diff_reg;

    // handshake: the pipeline advances unless the output holds a stalled result
    assign en            = !out_valid_reg || results.ready;
    assign items.ready   = en;
    assign results.valid = out_valid_reg;
    assign results.dropped_primal = out_primal_reg;
    assign results.dropped_dual   = out_dual_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[4:0], items.valid};
            out_valid_reg <= vld_reg[5];
        end
    end

    // stage 1 comparisons and operand routing
    always_comb
    begin
        s1_ctl_next.lb  = items.lower_bound;
        s1_ctl_next.ub  = items.upper_bound;
        s1_ctl_next.xv  = dtc_pkg::fp_lt(items.primal_value, items.lower_bound) ?
                          items.lower_bound : items.primal_value;
        s1_ctl_next.eq  = dtc_pkg::fp_eq(items.lower_bound, items.upper_bound);
        s1_ctl_next.gel = dtc_pkg::fp_ge(items.lower_dual, items.lower_slack);
        s1_ctl_next.geu = dtc_pkg::fp_ge(items.upper_dual, items.upper_slack);
        s1_ctl_next.hl  = items.has_lower;
        s1_ctl_next.hu  = items.has_upper;
        mul_a[0] = items.lower_dual;
        mul_b[0] = items.upper_slack;
        mul_a[1] = items.upper_dual;
        mul_b[1] = items.lower_slack;
    end

    // stage 2 clamp against the upper bound
    always_comb
    begin
        s2_ctl_next    = s1_ctl_reg;
        s2_ctl_next.xv = dtc_pkg::fp_lt(s1_ctl_reg.ub, s1_ctl_reg.xv) ?
                         s1_ctl_reg.ub : s1_ctl_reg.xv;
    end

    // control track, clamp finished in stage 2
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_ctl_reg    <= s1_ctl_next;
            s2_ctl_reg    <= s2_ctl_next;
            s3_ctl_reg    <= s2_ctl_reg;
            s4_ctl_reg    <= s3_ctl_reg;
            s5_ctl_reg    <= s4_ctl_reg;
            s6_ctl_reg    <= s5_ctl_reg;
        end
    end

    // multiplier lanes
    always_ff @(posedge clk)
    begin
        logic [52:0] ma, mb;
        logic signed [12:0] e;
        logic [12:0] s;
        logic [105:0] r;
        logic st;
        logic up;
        logic [62:0] mag;
        if (en)
        begin
            for (int k = 0; k < 2; k++)
            begin
                // stage 1: unpack and partial products
                ma = dtc_pkg::mant(mul_a[k]);
                mb = dtc_pkg::mant(mul_b[k]);
                s1_pphh_reg[k] <= ma[52:27] * mb[52:27];
                s1_pphl_reg[k] <= ma[52:27] * mb[26:0];
                s1_pplh_reg[k] <= ma[26:0] * mb[52:27];
                s1_ppll_reg[k] <= ma[26:0] * mb[26:0];
                s1_esum_reg[k] <= {1'b0, dtc_pkg::exp_eff(mul_a[k])} +
                                  {1'b0, dtc_pkg::exp_eff(mul_b[k])};
                s1_mf_reg[k].nan  <= dtc_pkg::is_nan(mul_a[k]) || dtc_pkg::is_nan(mul_b[k])
                    || (dtc_pkg::is_inf(mul_a[k]) && (mul_b[k][62:0] == 63'd0))
                    || (dtc_pkg::is_inf(mul_b[k]) && (mul_a[k][62:0] == 63'd0));
                s1_mf_reg[k].inf  <= dtc_pkg::is_inf(mul_a[k]) || dtc_pkg::is_inf(mul_b[k]);
                s1_mf_reg[k].zero <= (mul_a[k][62:0] == 63'd0) || (mul_b[k][62:0] == 63'd0);
                s1_mf_reg[k].sign <= mul_a[k][63] ^ mul_b[k][63];

                // stage 2: sum partial products
                s2_p_reg[k] <= (106'(s1_pphh_reg[k]) << 54)
                             + ((106'(s1_pphl_reg[k]) + 106'(s1_pplh_reg[k])) << 27)
                             + 106'(s1_ppll_reg[k]);
                s2_esum_reg[k] <= s1_esum_reg[k];
                s2_mf_reg[k]   <= s1_mf_reg[k];

                // stage 3: leading zero count
                s3_p_reg[k]    <= s2_p_reg[k];
                s3_lz_reg[k]   <= dtc_pkg::lzc106(s2_p_reg[k]);
                s3_esum_reg[k] <= s2_esum_reg[k];
                s3_mf_reg[k]   <= s2_mf_reg[k];

                // stage 4: normalize, biased exponent of the leading one
                s4_n_reg[k] <= s3_p_reg[k] << s3_lz_reg[k];
                s4_e_reg[k] <= $signed({1'b0, s3_esum_reg[k]}) - $signed({6'd0, s3_lz_reg[k]})
                               - 13'sd1022;
                s4_mf_reg[k] <= s3_mf_reg[k];

                // stage 5: subnormal right shift with sticky
                e = s4_e_reg[k];
                s = 13'(13'sd1 - e);
                if (e >= 13'sd1)
                begin
                    r  = s4_n_reg[k];
                    st = 1'b0;
                end
                else if (s > 13'd106)
                begin
                    r  = '0;
                    st = |s4_n_reg[k];
                end
                else
                begin
                    r  = s4_n_reg[k] >> s[6:0];
                    st = |(s4_n_reg[k] & ((106'd1 << s[6:0]) - 106'd1));
                end
                s5_ef_reg[k]   <= (e >= 13'sd1) ? e[10:0] : 11'd0;
                s5_ovf_reg[k]  <= (e >= 13'sd2047);
                s5_frac_reg[k] <= r[104:53];
                s5_g_reg[k]    <= r[52];
                s5_st_reg[k]   <= st || (|r[51:0]);
                s5_mf_reg[k]   <= s4_mf_reg[k];

                // stage 6: round to nearest even, specials
                up  = s5_g_reg[k] && (s5_st_reg[k] || s5_frac_reg[k][0]);
                mag = {s5_ef_reg[k], s5_frac_reg[k]} + 63'(up);
                if (s5_mf_reg[k].nan)
                    s6_prod_reg[k] <= dtc_pkg::DEFAULT_NAN;
                else if (s5_mf_reg[k].inf || s5_ovf_reg[k])
                    s6_prod_reg[k] <= {s5_mf_reg[k].sign, dtc_pkg::EXP_MAX, 52'd0};
                else if (s5_mf_reg[k].zero)
                    s6_prod_reg[k] <= {s5_mf_reg[k].sign, 63'd0};
                else
                    s6_prod_reg[k] <= {s5_mf_reg[k].sign, mag};
            end
        end
    end

    // subtract path: zl - zu
    always_ff @(posedge clk)
    begin
        dtc_pkg::dbl_t a, bn, big, lesser;
        logic [55:0] ext, sm;
        logic stk;
        logic spec;
        logic [5:0] sh;
        logic [55:0] m;
        logic [10:0] enew;
        logic up;
        logic [62:0] mag;
        if (en)
        begin
            // stage 1: unpack, order by magnitude, specials
            a   = items.lower_dual;
            bn  = {~items.upper_dual[63], items.upper_dual[62:0]};
            if (bn[62:0] > a[62:0])
            begin
                big    = bn;
                lesser = a;
            end
            else
            begin
                big    = a;
                lesser = bn;
            end
            s1_big_reg   <= dtc_pkg::mant(big);
            s1_small_reg <= dtc_pkg::mant(lesser);
            s1_ebig_reg  <= dtc_pkg::exp_eff(big);
            s1_d_reg     <= dtc_pkg::exp_eff(big) - dtc_pkg::exp_eff(lesser);
            s1_esub_reg  <= a[63] ^ bn[63];
            s1_rsign_reg <= big[63];
            spec = 1'b1;
            if (dtc_pkg::is_nan(a))
                s1_specval_reg <= a | dtc_pkg::QUIET_BIT;
            else if (dtc_pkg::is_nan(items.upper_dual))
                s1_specval_reg <= items.upper_dual | dtc_pkg::QUIET_BIT;
            else if (dtc_pkg::is_inf(a) && dtc_pkg::is_inf(bn))
                s1_specval_reg <= (a[63] != bn[63]) ? dtc_pkg::DEFAULT_NAN : a;
            else if (dtc_pkg::is_inf(a))
                s1_specval_reg <= a;
            else if (dtc_pkg::is_inf(bn))
                s1_specval_reg <= bn;
            else if ((a[62:0] == 63'd0) && (bn[62:0] == 63'd0))
                s1_specval_reg <= {a[63] & bn[63], 63'd0};
            else
            begin
                spec = 1'b0;
                s1_specval_reg <= dtc_pkg::POS_ZERO;
            end
            s1_spec_reg <= spec;

            // stage 2: align the smaller operand and add
            ext = {s1_small_reg, 3'b000};
            if (s1_d_reg >= 11'd56)
            begin
                sm  = '0;
                stk = |s1_small_reg;
            end
            else
            begin
                sm  = ext >> s1_d_reg[5:0];
                stk = |(ext & ((56'd1 << s1_d_reg[5:0]) - 56'd1));
            end
            sm[0] = sm[0] | stk;
            s2_sum_reg <= s1_esub_reg ? ({1'b0, s1_big_reg, 3'b000} - {1'b0, sm})
                                      : ({1'b0, s1_big_reg, 3'b000} + {1'b0, sm});
            s2_ebig_reg    <= s1_ebig_reg;
            s2_rsign_reg   <= s1_rsign_reg;
            s2_spec_reg    <= s1_spec_reg;
            s2_specval_reg <= s1_specval_reg;

            // stage 3: carry-out fixup, leading zero count
            if (s2_sum_reg[56])
            begin
                s3_n_reg      <= {s2_sum_reg[56:2], s2_sum_reg[1] | s2_sum_reg[0]};
                s3_e_reg      <= s2_ebig_reg + 11'd1;
                s3_lz_reg_sub <= 6'd0;
            end
            else
            begin
                s3_n_reg      <= s2_sum_reg[55:0];
                s3_e_reg      <= s2_ebig_reg;
                s3_lz_reg_sub <= dtc_pkg::lzc56(s2_sum_reg[55:0]);
            end
            s3_zero_reg    <= (s2_sum_reg == 57'd0);
            s3_rsign_reg   <= s2_rsign_reg;
            s3_spec_reg    <= s2_spec_reg;
            s3_specval_reg <= s2_specval_reg;

            // stage 4: normalize, limited by the subnormal exponent
            sh   = ({5'd0, s3_lz_reg_sub} < s3_e_reg) ? s3_lz_reg_sub : 6'(s3_e_reg - 11'd1);
            m    = s3_n_reg << sh;
            enew = s3_e_reg - {5'd0, sh};
            s4_m_reg       <= m;
            s4_ef_reg      <= m[55] ? enew : 11'd0;
            s4_ovf_reg     <= m[55] && (enew == dtc_pkg::EXP_MAX);
            s4_zero_reg    <= s3_zero_reg;
            s4_rsign_reg   <= s3_rsign_reg;
            s4_spec_reg    <= s3_spec_reg;
            s4_specval_reg <= s3_specval_reg;

            // stage 5: round to nearest even
            up  = s4_m_reg[2] && ((|s4_m_reg[1:0]) || s4_m_reg[3]);
            mag = {s4_ef_reg, s4_m_reg[54:3]} + 63'(up);
            if (s4_spec_reg)
                s5_diff_reg <= s4_specval_reg;
            else if (s4_zero_reg)
                s5_diff_reg <= dtc_pkg::POS_ZERO;
            else if (s4_ovf_reg)
                s5_diff_reg <= {s4_rsign_reg, dtc_pkg::EXP_MAX, 52'd0};
            else
                s5_diff_reg <= {s4_rsign_reg, mag};

            s6_diff_reg <= s5_diff_reg;
        end
    end

    // decision from stage 6
    side_t side;
    logic take_lower, take_upper;
    dtc_pkg::dbl_t dec_primal, dec_dual;

    always_comb
    begin
        priority if (s6_ctl_reg.hl && s6_ctl_reg.hu)
            side = dtc_pkg::fp_ge(s6_prod_reg[0], s6_prod_reg[1]) ? SIDE_LOWER : SIDE_UPPER;
        else if (s6_ctl_reg.hl)
            side = SIDE_LOWER;
        else if (s6_ctl_reg.hu)
            side = SIDE_UPPER;
        else
            side = SIDE_NONE;
        take_lower = !s6_ctl_reg.eq && (side == SIDE_LOWER) && s6_ctl_reg.gel;
        take_upper = !s6_ctl_reg.eq && (side == SIDE_UPPER) && s6_ctl_reg.geu;
        priority if (s6_ctl_reg.eq)
        begin
            dec_primal = s6_ctl_reg.lb;
            dec_dual   = s6_diff_reg;
        end
        else if (take_lower)
        begin
            dec_primal = s6_ctl_reg.lb;
            dec_dual   = dtc_pkg::fp_lt(dtc_pkg::POS_ZERO, s6_diff_reg) ?
                         s6_diff_reg : dtc_pkg::POS_ZERO;
        end
        else if (take_upper)
        begin
            dec_primal = s6_ctl_reg.ub;
            dec_dual   = dtc_pkg::fp_lt(s6_diff_reg, dtc_pkg::POS_ZERO) ?
                         s6_diff_reg : dtc_pkg::POS_ZERO;
        end
        else
        begin
            dec_primal = s6_ctl_reg.xv;
            dec_dual   = dtc_pkg::POS_ZERO;
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_primal_reg <= dec_primal;
            out_dual_reg   <= dec_dual;
        end
    end

    // fixed variable lands on its lower bound
    `DTC_ASSERT_NEXT(a_fixed_at_lb, en && vld_reg[5] && s6_ctl_reg.eq, results.dropped_primal == $past(s6_ctl_reg.lb))
    // lower side gives a nonnegative reduced cost
    `DTC_ASSERT_NEXT(a_lower_dual_sign, en && vld_reg[5] && take_lower, !results.dropped_dual[63])
    // upper side lands on the upper bound
    `DTC_ASSERT_NEXT(a_upper_at_ub, en && vld_reg[5] && take_upper, results.dropped_primal == $past(s6_ctl_reg.ub))
    // normalized product has its leading one in the top bit
    `DTC_ASSERT_NOW(a_mul_norm, vld_reg[3] && !s4_mf_reg[0].nan && !s4_mf_reg[0].inf && !s4_mf_reg[0].zero, s4_n_reg[0][105])

endmodule
